// ===== sv/wbss_pkg.sv =====
// Shared types and constants of the wildcard byte signature scanner.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package wbss_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 16;
    localparam int OFFSET_BITS_DEF       = 32;

    localparam int SIG_BYTES    = 16;               // bytes held by the pattern registers
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int CARE_W       = 2 * SIG_BYTES;
    localparam int LEN_W        = 5;
    localparam int RES_OFFSET_W = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CFG_DATA_W-1:0] PATTERN_RESET = '0;
    localparam logic [CARE_W-1:0]     CARE_RESET    = '1;
    localparam logic [LEN_W-1:0]      LENGTH_RESET  = 5'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_CARE_MASK    = 2'd2,
        CFG_LENGTH       = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                    found;
        logic [RES_OFFSET_W-1:0] offset;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/wbss_front.sv =====
// Front end: configuration registers, byte window, stream counter and the
// masked compare that classifies every accepted item. Uses wbss_pkg.
`default_nettype none

module wbss_front #(
    parameter int MAX_PATTERN_BYTES = wbss_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int OFFSET_BITS       = wbss_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    input  wire logic [wbss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [wbss_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 scan_valid,
    input  wire logic [7:0]                           data_byte,
    input  wire logic                                 end_of_stream,
    input  wire logic                                 queue_full,
    output wire logic                                 push,
    output wire wbss_pkg::result_t                    push_data
);

    localparam int LW = wbss_pkg::LEN_W;

    logic [wbss_pkg::CFG_DATA_W-1:0] pat_lo_reg, pat_hi_reg;
    logic [wbss_pkg::CARE_W-1:0]     care_reg;
    logic [LW-1:0]                   len_reg;

    logic [7:0]             win_reg   [MAX_PATTERN_BYTES];
    logic [7:0]             win_shift [MAX_PATTERN_BYTES];
    logic [OFFSET_BITS-1:0] cnt_reg, cnt_inc, n_wide, offset;
    logic                   reported_reg;

    logic [2*wbss_pkg::CFG_DATA_W-1:0] sig;
    logic [LW-1:0]          n_eff;
    logic [MAX_PATTERN_BYTES-1:0] byte_ok;
    logic                   accept, long_enough, hit;
    logic [63:0]            offset_ext;
    wbss_pkg::result_t      res;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= wbss_pkg::PATTERN_RESET;
            pat_hi_reg <= wbss_pkg::PATTERN_RESET;
            care_reg   <= wbss_pkg::CARE_RESET;
            len_reg    <= wbss_pkg::LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (wbss_pkg::cfg_reg_t'(cfg_index))
                wbss_pkg::CFG_PATTERN_LOW:  pat_lo_reg <= cfg_data;
                wbss_pkg::CFG_PATTERN_HIGH: pat_hi_reg <= cfg_data;
                wbss_pkg::CFG_CARE_MASK:    care_reg   <= cfg_data[wbss_pkg::CARE_W-1:0];
                wbss_pkg::CFG_LENGTH:       len_reg    <= cfg_data[LW-1:0];
                default:                    len_reg    <= len_reg;
            endcase
        end
    end

    assign sig    = {pat_hi_reg, pat_lo_reg};
    assign accept = scan_valid && !queue_full;

    // length clamped to 1..MAX_PATTERN_BYTES
    always_comb
    begin
        if (len_reg == '0)
            n_eff = LW'(1);
        else if (len_reg > LW'(MAX_PATTERN_BYTES))
            n_eff = LW'(MAX_PATTERN_BYTES);
        else
            n_eff = len_reg;
    end

    always_comb
    begin
        win_shift[0] = data_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++)
            win_shift[k] = win_reg[k-1];
    end

    // signature byte i lines up with the byte n-1-i steps back
    always_comb
    begin
        logic [7:0] got;
        logic [7:0] m;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            got = '0;
            for (int k = 0; k < MAX_PATTERN_BYTES; k++)
                if (LW'(k + i + 1) == n_eff)
                    got = win_shift[k];
            m = {{4{care_reg[2*i+1]}}, {4{care_reg[2*i]}}};
            byte_ok[i] = (LW'(i) >= n_eff) || (((got ^ sig[8*i +: 8]) & m) == 8'h00);
        end
    end

    assign cnt_inc     = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
    assign n_wide      = OFFSET_BITS'(n_eff);
    assign long_enough = cnt_inc >= n_wide;
    assign offset      = cnt_inc - n_wide;
    assign offset_ext  = 64'(offset);
    assign hit         = !reported_reg && long_enough && (&byte_ok);

    assign res.found  = hit;
    assign res.offset = hit ? offset_ext[wbss_pkg::RES_OFFSET_W-1:0] : '0;

    assign push      = accept && (hit || (!reported_reg && end_of_stream));
    assign push_data = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN_BYTES; k++)
                win_reg[k] <= '0;
            cnt_reg      <= '0;
            reported_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (end_of_stream)
            begin
                for (int k = 0; k < MAX_PATTERN_BYTES; k++)
                    win_reg[k] <= '0;
                cnt_reg      <= '0;
                reported_reg <= 1'b0;
            end
            else
            begin
                for (int k = 0; k < MAX_PATTERN_BYTES; k++)
                    win_reg[k] <= win_shift[k];
                cnt_reg      <= cnt_inc;
                reported_reg <= reported_reg || hit;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/wbss_queue.sv =====
// Short result queue between the front end and the output stage.
// Uses wbss_pkg for the entry type and depth.
`default_nettype none

module wbss_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire wbss_pkg::result_t push_data,
    input  wire logic              pop,
    output wire wbss_pkg::result_t pop_data,
    output wire logic              empty,
    output wire logic              full
);

    localparam int DEPTH = wbss_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    wbss_pkg::result_t mem [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] count_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= bump(wr_reg);
            if (pop)
                rd_reg <= bump(rd_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign pop_data = mem[rd_reg];
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));

endmodule

`default_nettype wire

// ===== sv/wbss_back.sv =====
// Output stage: holds one result item on the result channel until taken,
// refilled from the queue. Uses wbss_pkg.
`default_nettype none

module wbss_back (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 q_empty,
    input  wire wbss_pkg::result_t                    q_data,
    output wire logic                                 pop,
    input  wire logic                                 result_stall,
    output wire logic                                 result_valid,
    output wire logic                                 found,
    output wire logic [wbss_pkg::RES_OFFSET_W-1:0]    match_offset
);

    logic              valid_reg, valid_next;
    wbss_pkg::result_t data_reg;

    assign pop = !q_empty && (!valid_reg || !result_stall);

    always_comb
    begin
        if (pop)
            valid_next = 1'b1;
        else if (result_stall)
            valid_next = valid_reg;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= q_data;
    end

    assign result_valid = valid_reg;
    assign found        = data_reg.found;
    assign match_offset = data_reg.offset;

endmodule

`default_nettype wire

// ===== sv/wildcard_byte_signature_scan_top.sv =====
// Top level of the wildcard byte signature scanner: front end, result queue
// and output stage. Uses wbss_pkg, wbss_front, wbss_queue, wbss_back.
//
//  channel | signals                                   | handshake
//  scan    | data_byte, end_of_stream                  | scan_valid / scan_stall
//  result  | found, match_offset                       | result_valid / result_stall
//  cfg     | cfg_index, cfg_data                       | cfg_valid / cfg_ready (always 1)
//
// One byte per clock while scan_stall is low; a result item is written to the queue on the edge
// that accepts its byte, and the output register loads it from the queue once that register is free.
// The window compare is combinational; the queue holds two results.
// scan_stall rises only when the queue is full behind a stalled result.
// rst_n is asynchronous: window, counter and registers return to reset values.
`default_nettype none

module wildcard_byte_signature_scan_top #(
    parameter int MAX_PATTERN_BYTES = wbss_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int OFFSET_BITS       = wbss_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output wire logic                                 cfg_ready,
    input  wire logic [wbss_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [wbss_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 scan_valid,
    output wire logic                                 scan_stall,
    input  wire logic [7:0]                           data_byte,
    input  wire logic                                 end_of_stream,
    output wire logic                                 result_valid,
    input  wire logic                                 result_stall,
    output wire logic                                 found,
    output wire logic [wbss_pkg::RES_OFFSET_W-1:0]    match_offset
);

    logic              push, pop, q_empty, q_full;
    wbss_pkg::result_t push_data, q_data;

    assign cfg_ready  = 1'b1;
    assign scan_stall = q_full;

    wbss_front #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .OFFSET_BITS       (OFFSET_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .scan_valid    (scan_valid),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .queue_full    (q_full),
        .push          (push),
        .push_data     (push_data)
    );

    wbss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (q_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    wbss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_data),
        .pop          (pop),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .found        (found),
        .match_offset (match_offset)
    );

endmodule

`default_nettype wire

// ===== sv/wbss_checker.sv =====
// Port-level checks of the scanner, bound to the top level.
// Uses wbss_pkg for port widths.
`default_nettype none

module wbss_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 scan_stall,
    input  wire logic                                 result_valid,
    input  wire logic                                 result_stall,
    input  wire logic                                 found,
    input  wire logic [wbss_pkg::RES_OFFSET_W-1:0]    match_offset
);

    // a stalled result item holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(found) && $stable(match_offset))
        else $error("result item changed while stalled");

    // not-found items carry a zero offset
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> match_offset == '0)
        else $error("not-found item with nonzero offset");

    // input backpressure only while a result waits
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        scan_stall |-> result_valid)
        else $error("scan stalled with no result pending");

    // and only after the result side stalled
    a_stall_follows_stall: assert property (@(posedge clk) disable iff (!rst_n)
        scan_stall |-> $past(result_stall))
        else $error("scan stalled without downstream stall");

endmodule

bind wildcard_byte_signature_scan_top wbss_checker u_wbss_checker (.*);

`default_nettype wire

// ===== verif/tb_wildcard_byte_signature_scan_top.sv =====
// Self-checking bench for wildcard_byte_signature_scan_top: random streams with planted
// signatures, bursty sender, stalling receiver, in-bench predictor of every report.
// Depends on wbss_pkg and the scanner RTL only.
`timescale 1ns / 100ps

module tb_wildcard_byte_signature_scan_top;

    localparam int WIN_BYTES      = wbss_pkg::MAX_PATTERN_BYTES_DEF;
    localparam int TARGET_BYTES   = 1750;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } stream_byte_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_valid = 1'b0;
    wire logic                           cfg_ready;
    logic [wbss_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [wbss_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    logic                                scan_valid = 1'b0;
    wire logic                           scan_stall;
    logic [7:0]                          data_byte = '0;
    logic                                end_of_stream = 1'b0;
    wire logic                           result_valid;
    logic                                result_stall = 1'b0;
    wire logic                           found;
    wire logic [wbss_pkg::RES_OFFSET_W-1:0] match_offset;

    wildcard_byte_signature_scan_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .scan_valid    (scan_valid),
        .scan_stall    (scan_stall),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .found         (found),
        .match_offset  (match_offset)
    );

    // stimulus side
    stream_byte_t       byte_backlog [$];
    logic [7:0]         stream_q [$];
    int                 bytes_queued = 0;
    int                 bytes_taken = 0;
    bit                 scan_taken = 1'b0;
    int                 burst_left = 1;
    int                 gap_left = 0;
    logic [63:0]        cur_lo = wbss_pkg::PATTERN_RESET;
    logic [63:0]        cur_hi = wbss_pkg::PATTERN_RESET;
    logic [31:0]        cur_care = wbss_pkg::CARE_RESET;
    logic [4:0]         cur_len = wbss_pkg::LENGTH_RESET;

    // receiver stall pattern
    int                 stall_mode = 0;
    int                 stall_left = 100;
    logic [2:0]         stall_tick = '0;

    // predictor mirror of registers and scan state
    logic [63:0]        sig_lo = wbss_pkg::PATTERN_RESET;
    logic [63:0]        sig_hi = wbss_pkg::PATTERN_RESET;
    logic [31:0]        sig_care = wbss_pkg::CARE_RESET;
    logic [4:0]         sig_len = wbss_pkg::LENGTH_RESET;
    logic [7:0]         recent [WIN_BYTES];
    logic [31:0]        seen_count = '0;
    bit                 hit_reported = 1'b0;
    wbss_pkg::result_t  expected_reports [$];
    wbss_pkg::result_t  want;

    int                 errors = 0;
    int                 idle_cycles = 0;
    bit                 any_fire;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int clamp_len(input logic [4:0] v);
        if (v == 0)
            return 1;
        if (v > WIN_BYTES)
            return WIN_BYTES;
        return int'(v);
    endfunction

    function automatic logic [7:0] sig_byte_of(input logic [63:0] lo, input logic [63:0] hi,
                                               input int i);
        if (i < 8)
            return lo[8*i +: 8];
        return hi[8*(i-8) +: 8];
    endfunction

    function automatic logic [7:0] nibble_mask(input logic [31:0] care, input int i);
        return {{4{care[2*i+1]}}, {4{care[2*i]}}};
    endfunction

    task automatic scan_predict(input logic [7:0] b, input logic last);
        int                n;
        bit                hit;
        wbss_pkg::result_t r;
        n = clamp_len(sig_len);
        for (int k = WIN_BYTES - 1; k > 0; k--)
            recent[k] = recent[k-1];
        recent[0] = b;
        if (seen_count != '1)
            seen_count = seen_count + 32'd1;
        hit = (seen_count >= n);
        // signature byte 0 lines up with the oldest of the newest n bytes
        for (int i = 0; i < n; i++) begin
            if (((recent[n-1-i] ^ sig_byte_of(sig_lo, sig_hi, i)) & nibble_mask(sig_care, i)) != 0)
                hit = 1'b0;
        end
        if (!hit_reported && hit) begin
            hit_reported = 1'b1;
            r.found = 1'b1;
            r.offset = seen_count - 32'(n);
            expected_reports.push_back(r);
        end
        else if (!hit_reported && last) begin
            r.found = 1'b0;
            r.offset = '0;
            expected_reports.push_back(r);
        end
        if (last) begin
            for (int k = 0; k < WIN_BYTES; k++)
                recent[k] = '0;
            seen_count = '0;
            hit_reported = 1'b0;
        end
    endtask

    task automatic push_byte(input logic [7:0] v, input logic last);
        stream_byte_t it;
        it.value = v;
        it.last = last;
        byte_backlog.push_back(it);
        bytes_queued++;
    endtask

    task automatic write_reg(input wbss_pkg::cfg_reg_t idx, input logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_signature(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [31:0] care, input logic [4:0] len);
        cur_lo = lo;
        cur_hi = hi;
        cur_care = care;
        cur_len = len;
        write_reg(wbss_pkg::CFG_PATTERN_LOW, lo);
        write_reg(wbss_pkg::CFG_PATTERN_HIGH, hi);
        write_reg(wbss_pkg::CFG_CARE_MASK, {32'd0, care});
        write_reg(wbss_pkg::CFG_LENGTH, {59'd0, len});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // cared nibbles from the signature, wildcard nibbles random (zero included)
    task automatic plant_at(input int at, input int n);
        logic [7:0] m;
        for (int i = 0; i < n; i++) begin
            m = nibble_mask(cur_care, i);
            stream_q[at+i] = (sig_byte_of(cur_lo, cur_hi, i) & m)
                           | (8'($urandom_range(0, 255)) & ~m);
        end
    endtask

    task automatic queue_stream(input bit close);
        int n;
        int total;
        int kind;
        int at;
        int pick;
        n = clamp_len(cur_len);
        total = n + $urandom_range(0, 24);
        kind = $urandom_range(0, 19);
        stream_q.delete();
        for (int i = 0; i < total; i++)
            stream_q.push_back(8'($urandom_range(0, 255)));
        if (kind < 16) begin
            at = $urandom_range(0, total - n);
            plant_at(at, n);
            if (kind >= 12 && kind < 15) begin
                // near miss: break one cared nibble of a random byte, if that byte has one
                pick = $urandom_range(0, n - 1);
                if (cur_care[2*pick])
                    stream_q[at+pick] = stream_q[at+pick] ^ 8'h01;
                else if (cur_care[2*pick+1])
                    stream_q[at+pick] = stream_q[at+pick] ^ 8'h10;
            end
            if (kind == 15)
                plant_at($urandom_range(0, total - n), n);
        end
        for (int i = 0; i < total; i++)
            push_byte(stream_q[i], close && (i == total - 1));
    endtask

    task automatic pick_signature();
        int sel;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [31:0] care;
        logic [4:0]  len;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            lo = '0;
            hi = '0;
        end
        else if (sel == 1) begin
            lo = '1;
            hi = '1;
        end
        sel = $urandom_range(0, 7);
        case (sel)
            0: care = '1;
            1: care = '0;
            2, 3, 4: care = $urandom | $urandom;
            default: care = $urandom;
        endcase
        sel = $urandom_range(0, 11);
        case (sel)
            0: len = 5'd0;
            1: len = 5'd31;
            2: len = 5'($urandom_range(17, 30));
            3: len = 5'd16;
            4: len = 5'd1;
            default: len = 5'($urandom_range(1, 8));
        endcase
        set_signature(lo, hi, care, len);
    endtask

    // sender: bursts of random length, random gaps, payload held while stalled
    always @(negedge clk) begin
        stream_byte_t it;
        if (!rst_n) begin
            scan_valid <= 1'b0;
        end
        else if (!scan_valid || scan_taken) begin
            scan_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                scan_valid <= 1'b0;
            end
            else if (byte_backlog.size() > 0) begin
                it = byte_backlog.pop_front();
                scan_valid <= 1'b1;
                data_byte <= it.value;
                end_of_stream <= it.last;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else begin
                    burst_left--;
                end
            end
            else begin
                scan_valid <= 1'b0;
            end
        end
    end

    // receiver stall: the mode is redrawn whenever stall_left runs out
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 300);
        end
        else begin
            stall_left--;
        end
        stall_tick = stall_tick + 3'd1;
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 3) == 0);
            2: result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= (stall_tick < 3'd5);
        endcase
    end

    // monitor: register mirror, prediction, report check, watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            any_fire = 1'b0;
            if (cfg_valid && cfg_ready) begin
                any_fire = 1'b1;
                case (wbss_pkg::cfg_reg_t'(cfg_index))
                    wbss_pkg::CFG_PATTERN_LOW:  sig_lo = cfg_data;
                    wbss_pkg::CFG_PATTERN_HIGH: sig_hi = cfg_data;
                    wbss_pkg::CFG_CARE_MASK:    sig_care = cfg_data[31:0];
                    wbss_pkg::CFG_LENGTH:       sig_len = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (scan_valid && !scan_stall) begin
                any_fire = 1'b1;
                scan_predict(data_byte, end_of_stream);
                scan_taken = 1'b1;
                bytes_taken++;
            end
            if (result_valid && !result_stall) begin
                any_fire = 1'b1;
                if (expected_reports.size() == 0) begin
                    errors++;
                    $display("%0t: report with none expected, actual found=%0b offset=%0d",
                             $time, found, match_offset);
                end
                else begin
                    want = expected_reports.pop_front();
                    if (found !== want.found) begin
                        errors++;
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, found);
                    end
                    if (match_offset !== want.offset) begin
                        errors++;
                        $display("%0t: match_offset expected %0d actual %0d",
                                 $time, want.offset, match_offset);
                    end
                end
            end
            if (any_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        int nstreams;
        for (int k = 0; k < WIN_BYTES; k++)
            recent[k] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset signature: one byte 00, all nibbles cared
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);        // match on the final byte
        push_byte(8'hFF, 1'b1);        // not found
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);        // already matched, nothing
        wait_drained();

        // length 0 acts as 1; only the low nibble is cared
        set_signature(64'h0000_0000_0000_00A5, 64'h0, 32'h0000_0001, 5'd0);
        push_byte(8'hF5, 1'b1);
        wait_drained();

        // length 31 clamps to 16, all wildcards: short stream, then a full one
        set_signature('1, '1, '0, 5'd31);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        for (int i = 0; i < WIN_BYTES; i++)
            push_byte(8'($urandom_range(0, 255)), i == WIN_BYTES - 1);
        wait_drained();

        // some phases leave the stream open so the next write lands mid-stream
        while (bytes_queued < TARGET_BYTES) begin
            pick_signature();
            nstreams = $urandom_range(2, 8);
            for (int s = 0; s < nstreams; s++)
                queue_stream(!(s == nstreams - 1 && $urandom_range(0, 3) == 0));
            wait_drained();
        end

        if (errors == 0 && expected_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/wbss_pkg.sv
sv/wbss_front.sv
sv/wbss_queue.sv
sv/wbss_back.sv
sv/wildcard_byte_signature_scan_top.sv
sv/wbss_checker.sv
verif/tb_wildcard_byte_signature_scan_top.sv
